// File: design/huffman_code_table_bit_packer_macros.svh
// Assertion macros for the Huffman code table bit packer.
// Included by the top level; needs nothing else.
`ifndef HUFFMAN_CODE_TABLE_BIT_PACKER_MACROS_SVH
`define HUFFMAN_CODE_TABLE_BIT_PACKER_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define HCTBP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define HCTBP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/hctbp_pkg.sv
// Shared types and constants for the Huffman code table bit packer.
// No dependencies; used by the packer datapath and the top level.
package hctbp_pkg;

    localparam int SYM_W            = 8;
    localparam int CODE_IN_W        = 32;
    localparam int IN_LEN_W         = 6;
    localparam int BYTE_W           = 8;
    localparam int CNT_W            = 3;
    localparam int STORE_DEPTH      = 256;
    localparam int MAX_CODE_LEN_DEF = 32;

    // Input commands; the fourth code is ignored.
    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2
    } cmd_t;

    // Sequencer controls to the packer datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic clear;
    } pk_ctrl_t;

    // Packer status back to the sequencer.
    typedef struct packed {
        logic              rem_zero;
        logic              full;
        logic [BYTE_W-1:0] data_byte;
        logic [CNT_W-1:0]  bit_count;
    } pk_stat_t;

endpackage

// File: design/hctbp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module hctbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/hctbp_packer.sv
// Bit packer datapath: code shift register, byte buffer and the shared merge unit.
// Depends on hctbp_pkg.
module hctbp_packer #(
    parameter int CODE_W = hctbp_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  hctbp_pkg::pk_ctrl_t          ctrl,
    input  logic [$clog2(CODE_W+1)-1:0]  load_len,
    input  logic [CODE_W-1:0]            load_code,
    output hctbp_pkg::pk_stat_t          stat
);
    import hctbp_pkg::*;

    localparam int LEN_W = $clog2(CODE_W + 1);
    localparam int SR_W  = CODE_W + 7;
    localparam int SH_W  = $clog2(SR_W + 1);
    localparam int CMP_W = (LEN_W > 4) ? LEN_W : 4;

    logic [SR_W-1:0]   sr_reg,  sr_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [BYTE_W-1:0] buf_reg, buf_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [3:0]        space;
    logic [3:0]        take;
    logic [3:0]        cnt_sum;
    logic [BYTE_W-1:0] chunk;
    logic [BYTE_W-1:0] merged;
    logic              full;

    // Shared merge unit: move as many code bits as fit into the byte buffer.
    always_comb begin
        space   = 4'(BYTE_W) - {1'b0, cnt_reg};
        take    = (CMP_W'(rem_reg) >= CMP_W'(space)) ? space : 4'(rem_reg);
        chunk   = sr_reg[SR_W-1 -: BYTE_W];
        merged  = buf_reg | (chunk >> cnt_reg);
        cnt_sum = {1'b0, cnt_reg} + take;
        full    = cnt_sum[3];
    end

    // Next-state selection for load, step and clear.
    always_comb begin
        sr_next  = sr_reg;
        rem_next = rem_reg;
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (ctrl.load) begin
            sr_next  = SR_W'(load_code) << (SH_W'(SR_W) - SH_W'(load_len));
            rem_next = load_len;
        end else if (ctrl.step) begin
            sr_next  = sr_reg << take;
            rem_next = rem_reg - LEN_W'(take);
            if (full) begin
                buf_next = '0;
                cnt_next = '0;
            end else begin
                buf_next = merged;
                cnt_next = cnt_sum[CNT_W-1:0];
            end
        end
        if (ctrl.clear) begin
            buf_next = '0;
            cnt_next = '0;
        end
    end

    // Buffer state is cleared by reset; the code shift register is payload.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
            buf_reg <= '0;
            cnt_reg <= '0;
        end else begin
            rem_reg <= rem_next;
            buf_reg <= buf_next;
            cnt_reg <= cnt_next;
        end
        sr_reg <= sr_next;
    end

    assign stat.rem_zero  = (rem_reg == '0);
    assign stat.full      = full;
    assign stat.data_byte = full ? merged : buf_reg;
    assign stat.bit_count = cnt_reg;

endmodule

// File: design/huffman_code_table_bit_packer.sv
// Huffman code table bit packer.
// Input commands arrive on the s_ channel as one word each: write code entry,
// encode symbol or flush trailer. Packed bytes leave on the m_ channel, one
// word per byte, with m_last set on the count byte that ends a flush.
// The block takes one command at a time; s_ready is high only between commands.
// A write leaves s_ready high, so writes can be taken every cycle.
// An encode holds s_ready low through ST_LOAD, which aligns the code, then ST_STEP,
// which makes one merge of up to 8 code bits into the byte buffer per step until
// no code bits remain, and then returns to idle; the merge unit sets the bits per merge.
// A flush holds s_ready low through ST_FLUSH_DATA and ST_FLUSH_CNT and emits the partial byte and the bit count.
// A single output register holds the next word; when the receiver stalls the
// sequencer waits before any merge that completes a byte and before each flush
// stage, so nothing is lost, and the command in progress waits with it.
// Reset clears the code store valid bits (all codes length zero), the byte
// buffer and the bit count together; no clearing pass is needed.
// An encode of a symbol with no code emits nothing; command 3 is ignored.
// Depends on hctbp_pkg, hctbp_ram, hctbp_packer and the assertion macros.
`include "huffman_code_table_bit_packer_macros.svh"

module huffman_code_table_bit_packer #(
    parameter int MAX_CODE_LEN = hctbp_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_command,
    input  logic [hctbp_pkg::SYM_W-1:0]      s_symbol,
    input  logic [hctbp_pkg::CODE_IN_W-1:0]  s_code_bits,
    input  logic [hctbp_pkg::IN_LEN_W-1:0]   s_code_length,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [hctbp_pkg::BYTE_W-1:0]     m_out_byte,
    output logic                             m_last
);
    import hctbp_pkg::*;

    localparam int CODE_W  = (MAX_CODE_LEN < CODE_IN_W) ? MAX_CODE_LEN : CODE_IN_W;
    localparam int LEN_W   = $clog2(CODE_W + 1);
    localparam int STORE_W = LEN_W + CODE_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_STEP,
        ST_FLUSH_DATA,
        ST_FLUSH_CNT
    } state_t;

    state_t             state_reg;
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic               out_last_reg;
    logic [STORE_DEPTH-1:0] entry_valid_reg;
    logic               rd_valid_reg;

    logic               accept;
    logic               slot_free;
    logic               out_load;
    logic               wr_en;
    logic               rd_en;
    logic [LEN_W-1:0]   wr_len;
    logic [CODE_W-1:0]  wr_mask;
    logic [STORE_W-1:0] wr_data;
    logic [STORE_W-1:0] rd_data;
    logic [LEN_W-1:0]   load_len;
    pk_ctrl_t           ctrl;
    pk_stat_t           stat;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign slot_free = !out_valid_reg || m_ready;

    // Code store write: clamp the length and drop code bits above it.
    always_comb begin
        if (s_code_length > IN_LEN_W'(CODE_W)) begin
            wr_len = LEN_W'(CODE_W);
        end else begin
            wr_len = s_code_length[LEN_W-1:0];
        end
        wr_mask = ~({CODE_W{1'b1}} << wr_len);
        wr_data = {wr_len, s_code_bits[CODE_W-1:0] & wr_mask};
        wr_en   = accept && (s_command == CMD_WRITE);
        rd_en   = accept && (s_command == CMD_ENCODE);
    end

    hctbp_ram #(
        .WIDTH (STORE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s_symbol),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (s_symbol),
        .rd_data (rd_data)
    );

    // An entry never written since reset reads as length zero.
    assign load_len = rd_valid_reg ? rd_data[STORE_W-1 -: LEN_W] : '0;

    // Datapath controls decoded from the sequencer state.
    always_comb begin
        ctrl.load  = (state_reg == ST_LOAD);
        ctrl.step  = (state_reg == ST_STEP) && !stat.rem_zero && (!stat.full || slot_free);
        ctrl.clear = (state_reg == ST_FLUSH_CNT) && slot_free;
    end

    // A word enters the output register from a completing merge or a flush stage.
    assign out_load = (ctrl.step && stat.full)
                   || (((state_reg == ST_FLUSH_DATA) || (state_reg == ST_FLUSH_CNT))
                       && slot_free);

    hctbp_packer #(
        .CODE_W (CODE_W)
    ) u_packer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .load_len  (load_len),
        .load_code (rd_data[CODE_W-1:0]),
        .stat      (stat)
    );

    // Store valid bits, cleared together by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
        end else if (wr_en) begin
            entry_valid_reg[s_symbol] <= 1'b1;
        end
        if (rd_en) begin
            rd_valid_reg <= entry_valid_reg[s_symbol];
        end
    end

    // Sequencer and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (m_ready && !out_load) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        case (s_command)
                            CMD_ENCODE: state_reg <= ST_LOAD;
                            CMD_FLUSH:  state_reg <= ST_FLUSH_DATA;
                            default:    state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_LOAD: begin
                    state_reg <= ST_STEP;
                end
                ST_STEP: begin
                    if (stat.rem_zero) begin
                        state_reg <= ST_IDLE;
                    end else if (ctrl.step && stat.full) begin
                        out_valid_reg <= 1'b1;
                        out_byte_reg  <= stat.data_byte;
                        out_last_reg  <= 1'b0;
                    end
                end
                ST_FLUSH_DATA: begin
                    if (slot_free) begin
                        out_valid_reg <= 1'b1;
                        out_byte_reg  <= stat.data_byte;
                        out_last_reg  <= 1'b0;
                        state_reg     <= ST_FLUSH_CNT;
                    end
                end
                ST_FLUSH_CNT: begin
                    if (slot_free) begin
                        out_valid_reg <= 1'b1;
                        out_byte_reg  <= BYTE_W'(stat.bit_count);
                        out_last_reg  <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_out_byte = out_byte_reg;
    assign m_last     = out_last_reg;

    // A merge that completes a byte only happens when the output slot is free.
    `HCTBP_ASSERT_NOW(a_no_overwrite, aclk, aresetn, ctrl.step && stat.full, slot_free, "byte merged into a busy output register")
    // A completed byte is presented on the next cycle.
    `HCTBP_ASSERT_NEXT(a_byte_shown, aclk, aresetn, ctrl.step && stat.full, m_valid && !m_last, "completed byte not presented")
    // An accepted flush goes straight to emitting the partial byte.
    `HCTBP_ASSERT_NEXT(a_flush_start, aclk, aresetn, accept && (s_command == CMD_FLUSH), state_reg == ST_FLUSH_DATA, "flush did not start")

endmodule
